>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low asynchronous reset.
`define PSAM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Same-cycle implication.
`define PSAM_ASSERT_IMP(label, clk, rst_n, trig, cons, msg) \
	`PSAM_ASSERT(label, clk, rst_n, (trig) |-> (cons), msg)

// Next-cycle implication.
`define PSAM_ASSERT_NXT(label, clk, rst_n, trig, cons, msg) \
	`PSAM_ASSERT(label, clk, rst_n, (trig) |=> (cons), msg)

`endif

>>> rtl/core/psam_pkg.sv
// Package of the padding source address mapper: widths, register indexes,
// stage codes and the structs that travel between the modules. No dependencies.
`timescale 1ns / 1ps

package psam_pkg;

	localparam int ADDR_W     = 50;
	localparam int EXT_W      = 11;
	localparam int CH_W       = 13;
	localparam int POS_W      = 12;
	localparam int BATCH_W    = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;
	localparam int MAP_W      = 15;
	localparam int PIPE_DEPTH = 5;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 4'd0,
		REG_CHANNELS  = 4'd1,
		REG_DEPTH     = 4'd2,
		REG_HEIGHT    = 4'd3,
		REG_WIDTH     = 4'd4,
		REG_PAD_FRONT = 4'd5,
		REG_PAD_TOP   = 4'd6,
		REG_PAD_LEFT  = 4'd7
	} psam_reg_e;

	// Which extent and index a multiply-add step folds in.
	typedef enum logic [1:0] {
		STEP_CHAN  = 2'd0,
		STEP_DEPTH = 2'd1,
		STEP_ROW   = 2'd2,
		STEP_COL   = 2'd3
	} psam_step_e;

	typedef struct packed {
		logic                    repl;
		logic                    last;
		logic [CH_W-1:0]         chans;
		logic [EXT_W-1:0]        depth;
		logic [EXT_W-1:0]        height;
		logic [EXT_W-1:0]        width;
		logic signed [EXT_W-1:0] pad_front;
		logic signed [EXT_W-1:0] pad_top;
		logic signed [EXT_W-1:0] pad_left;
	} psam_cfg_t;

	typedef struct packed {
		logic [BATCH_W-1:0] batch;
		logic [POS_W-1:0]   chan;
		logic [POS_W-1:0]   plane;
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
	} psam_pos_t;

	typedef struct packed {
		logic [ADDR_W-1:0] acc;
		logic [EXT_W-1:0]  id;
		logic [EXT_W-1:0]  ih;
		logic [EXT_W-1:0]  iw;
		logic [POS_W-1:0]  chan;
		logic              bad;
		logic              inner;
	} psam_item_t;

endpackage

>>> rtl/core/psam_if.sv
// Channel interfaces of the padding source address mapper: positions in,
// addresses out, configuration writes. Depends on psam_pkg.
`timescale 1ns / 1ps

interface psam_pos_if;
	import psam_pkg::*;
	logic               valid;
	logic               ready;
	logic [BATCH_W-1:0] batch_idx;
	logic [POS_W-1:0]   chan_idx;
	logic [POS_W-1:0]   out_plane;
	logic [POS_W-1:0]   out_row;
	logic [POS_W-1:0]   out_col;
	modport source (output valid, batch_idx, chan_idx, out_plane, out_row, out_col,
		input ready);
	modport sink (input valid, batch_idx, chan_idx, out_plane, out_row, out_col,
		output ready);
endinterface

interface psam_addr_if;
	import psam_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] source_address;
	logic              out_of_range;
	logic              is_interior;
	modport source (output valid, source_address, out_of_range, is_interior,
		input ready);
	modport sink (input valid, source_address, out_of_range, is_interior,
		output ready);
endinterface

interface psam_cfg_if;
	import psam_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/psam_axis_map.sv
// Maps one output position onto the unpadded input along a single axis,
// by reflection or replication. Depends on psam_pkg.
`timescale 1ns / 1ps

module psam_axis_map (
	input  logic [psam_pkg::POS_W-1:0]        pos,
	input  logic [psam_pkg::EXT_W-1:0]        extent,
	input  logic signed [psam_pkg::EXT_W-1:0] pad,
	input  logic                              repl,
	output logic [psam_pkg::EXT_W-1:0]        idx,
	output logic                              bad,
	output logic                              edge_hit
);
	import psam_pkg::*;

	logic signed [MAP_W-1:0] js;
	logic signed [MAP_W-1:0] ss;
	logic signed [MAP_W-1:0] ps;
	logic signed [MAP_W-1:0] mv;
	logic                    below;
	logic                    above;

	assign js = $signed({{(MAP_W-POS_W){1'b0}}, pos});
	assign ss = $signed({{(MAP_W-EXT_W){1'b0}}, extent});
	assign ps = $signed({{(MAP_W-EXT_W){pad[EXT_W-1]}}, pad});

	assign below = js < ps;
	assign above = js >= (ss + ps);

	always_comb begin
		priority if (below) begin
			mv = repl ? '0 : ps - js;
		end else if (!above) begin
			mv = js - ps;
		end else begin
			// Mirror about the high edge without repeating it, or clamp to it.
			mv = repl ? ss - MAP_W'(1) : (ss <<< 1) + ps - MAP_W'(2) - js;
		end
	end

	assign edge_hit = below || above;
	assign bad      = (mv < 0) || (mv >= ss);
	assign idx      = mv[EXT_W-1:0];

endmodule

>>> rtl/core/psam_map.sv
// Front stage logic: maps depth, row and column and seeds the address
// accumulator with the batch index. Depends on psam_pkg and psam_axis_map.
`timescale 1ns / 1ps

module psam_map (
	input  psam_pkg::psam_pos_t  pos,
	input  psam_pkg::psam_cfg_t  cfg,
	output psam_pkg::psam_item_t item
);
	import psam_pkg::*;

	logic [EXT_W-1:0] id;
	logic [EXT_W-1:0] ih;
	logic [EXT_W-1:0] iw;
	logic [2:0]       bad;
	logic [2:0]       hit;

	psam_axis_map u_depth (
		.pos(pos.plane), .extent(cfg.depth), .pad(cfg.pad_front), .repl(cfg.repl),
		.idx(id), .bad(bad[0]), .edge_hit(hit[0])
	);

	psam_axis_map u_row (
		.pos(pos.row), .extent(cfg.height), .pad(cfg.pad_top), .repl(cfg.repl),
		.idx(ih), .bad(bad[1]), .edge_hit(hit[1])
	);

	psam_axis_map u_col (
		.pos(pos.col), .extent(cfg.width), .pad(cfg.pad_left), .repl(cfg.repl),
		.idx(iw), .bad(bad[2]), .edge_hit(hit[2])
	);

	always_comb begin
		item.acc   = ADDR_W'(pos.batch);
		item.id    = id;
		item.ih    = ih;
		item.iw    = iw;
		item.chan  = pos.chan;
		item.bad   = |bad;
		item.inner = ~|hit;
	end

endmodule

>>> rtl/core/psam_mac.sv
// One multiply-add step of the flat address: acc * extent + index.
// Depends on psam_pkg.
`timescale 1ns / 1ps

module psam_mac (
	input  psam_pkg::psam_item_t item,
	input  psam_pkg::psam_cfg_t  cfg,
	input  psam_pkg::psam_step_e step,
	output psam_pkg::psam_item_t result
);
	import psam_pkg::*;

	psam_step_e               slot;
	logic [CH_W-1:0]          factor;
	logic [POS_W-1:0]         addend;
	logic [ADDR_W+CH_W-1:0]   prod;

	// Channels-last folds the channel in at the end, so its order is rotated by one.
	assign slot = psam_step_e'(step + 2'(cfg.last));

	always_comb begin
		unique case (slot)
			STEP_CHAN: begin
				factor = cfg.chans;
				addend = item.chan;
			end
			STEP_DEPTH: begin
				factor = CH_W'(cfg.depth);
				addend = POS_W'(item.id);
			end
			STEP_ROW: begin
				factor = CH_W'(cfg.height);
				addend = POS_W'(item.ih);
			end
			STEP_COL: begin
				factor = CH_W'(cfg.width);
				addend = POS_W'(item.iw);
			end
			default: begin
				factor = '0;
				addend = '0;
			end
		endcase
	end

	assign prod = (ADDR_W+CH_W)'(item.acc) * (ADDR_W+CH_W)'(factor);

	always_comb begin
		result     = item;
		result.acc = prod[ADDR_W-1:0] + ADDR_W'(addend);
	end

endmodule

>>> rtl/core/pad_source_address_mapper_top.sv
// Top level of the padding source address mapper: configuration registers,
// the five-stage pipeline and its handshake. Depends on psam_pkg, psam_if,
// psam_map and psam_mac.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+----------------------------------------------
//   pos     | in  | valid/ready     | batch_idx, chan_idx, out_plane/row/col
//   addr    | out | valid/ready     | source_address, out_of_range, is_interior
//   cfg     | in  | valid/ready(=1) | index, data
//
// One position beat is taken every cycle while the addr channel does not stall; its
// result moves through the stage registers s1 to s5 and is presented from s5.
// The depth is set by the mapping stage plus four multiply-add stages, each with one
// multiplier of at most 50 by 13 bits.
// Reset clears all stage valid bits and returns the registers to their defaults.
// A stall on addr backs up only as far as the first empty stage; bubbles collapse.
`timescale 1ns / 1ps

module pad_source_address_mapper_top (
	input  logic          clk,
	input  logic          arst_n,
	psam_pos_if.sink      pos,
	psam_addr_if.source   addr,
	psam_cfg_if.sink      cfg
);
	import psam_pkg::*;

	// Configuration registers. Writes are only expected while the pipeline is idle,
	// so the stages read them directly.
	logic [MODE_W-1:0]       mode_q;
	logic [CH_W-1:0]         chans_q;
	logic [EXT_W-1:0]        depth_q;
	logic [EXT_W-1:0]        height_q;
	logic [EXT_W-1:0]        width_q;
	logic signed [EXT_W-1:0] pad_front_q;
	logic signed [EXT_W-1:0] pad_top_q;
	logic signed [EXT_W-1:0] pad_left_q;
	psam_cfg_t               cfg_w;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= '0;
			chans_q     <= CH_W'(1);
			depth_q     <= EXT_W'(1);
			height_q    <= EXT_W'(1);
			width_q     <= EXT_W'(1);
			pad_front_q <= '0;
			pad_top_q   <= '0;
			pad_left_q  <= '0;
		end else if (cfg.valid) begin
			unique case (psam_reg_e'(cfg.index))
				REG_MODE:      mode_q      <= cfg.data[MODE_W-1:0];
				REG_CHANNELS:  chans_q     <= cfg.data[CH_W-1:0];
				REG_DEPTH:     depth_q     <= cfg.data[EXT_W-1:0];
				REG_HEIGHT:    height_q    <= cfg.data[EXT_W-1:0];
				REG_WIDTH:     width_q     <= cfg.data[EXT_W-1:0];
				REG_PAD_FRONT: pad_front_q <= $signed(cfg.data[EXT_W-1:0]);
				REG_PAD_TOP:   pad_top_q   <= $signed(cfg.data[EXT_W-1:0]);
				REG_PAD_LEFT:  pad_left_q  <= $signed(cfg.data[EXT_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_w.repl      = mode_q[0];
		cfg_w.last      = mode_q[1];
		cfg_w.chans     = chans_q;
		cfg_w.depth     = depth_q;
		cfg_w.height    = height_q;
		cfg_w.width     = width_q;
		cfg_w.pad_front = pad_front_q;
		cfg_w.pad_top   = pad_top_q;
		cfg_w.pad_left  = pad_left_q;
	end

	// Stage 1: per-axis mapping. Stages 2 to 5: the four multiply-add steps.
	psam_pos_t  pos_w;
	psam_item_t map_w;
	psam_item_t mac2_w;
	psam_item_t mac3_w;
	psam_item_t mac4_w;
	psam_item_t mac5_w;

	psam_item_t item_s1;
	psam_item_t item_s2;
	psam_item_t item_s3;
	psam_item_t item_s4;
	psam_item_t item_s5;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       valid_s4;
	logic       valid_s5;

	// A stage loads when it is empty or its content moves on in the same cycle.
	logic ld1;
	logic ld2;
	logic ld3;
	logic ld4;
	logic ld5;

	assign ld5 = !valid_s5 || addr.ready;
	assign ld4 = !valid_s4 || ld5;
	assign ld3 = !valid_s3 || ld4;
	assign ld2 = !valid_s2 || ld3;
	assign ld1 = !valid_s1 || ld2;

	assign pos.ready = ld1;

	always_comb begin
		pos_w.batch = pos.batch_idx;
		pos_w.chan  = pos.chan_idx;
		pos_w.plane = pos.out_plane;
		pos_w.row   = pos.out_row;
		pos_w.col   = pos.out_col;
	end

	psam_map u_map (.pos(pos_w), .cfg(cfg_w), .item(map_w));

	psam_mac u_mac2 (.item(item_s1), .cfg(cfg_w), .step(STEP_CHAN),  .result(mac2_w));
	psam_mac u_mac3 (.item(item_s2), .cfg(cfg_w), .step(STEP_DEPTH), .result(mac3_w));
	psam_mac u_mac4 (.item(item_s3), .cfg(cfg_w), .step(STEP_ROW),   .result(mac4_w));
	psam_mac u_mac5 (.item(item_s4), .cfg(cfg_w), .step(STEP_COL),   .result(mac5_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= pos.valid;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3;
			if (ld5) valid_s5 <= valid_s4;
		end
	end

	// Payload registers carry no reset; they only load behind a valid beat.
	always_ff @(posedge clk) begin
		if (ld1 && pos.valid) item_s1 <= map_w;
		if (ld2 && valid_s1)  item_s2 <= mac2_w;
		if (ld3 && valid_s2)  item_s3 <= mac3_w;
		if (ld4 && valid_s3)  item_s4 <= mac4_w;
		if (ld5 && valid_s4)  item_s5 <= mac5_w;
	end

	// An out-of-range position reports address zero, whatever was accumulated.
	assign addr.valid          = valid_s5;
	assign addr.source_address = item_s5.bad ? '0 : item_s5.acc;
	assign addr.out_of_range   = item_s5.bad;
	assign addr.is_interior    = item_s5.inner;

endmodule

>>> rtl/core/psam_checker.sv
// Port-level checker for the padding source address mapper and its bind.
// Depends on psam_pkg, assert_macros.svh and pad_source_address_mapper_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psam_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        pos_valid,
	input logic                        pos_ready,
	input logic                        addr_valid,
	input logic                        addr_ready,
	input logic [psam_pkg::ADDR_W-1:0] source_address,
	input logic                        out_of_range,
	input logic                        is_interior
);
	import psam_pkg::*;

	logic [CNT_W-1:0] inflight_q;
	logic             in_beat;
	logic             out_beat;

	assign in_beat  = pos_valid && pos_ready;
	assign out_beat = addr_valid && addr_ready;

	// Beats accepted whose results have not been delivered yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_beat) - CNT_W'(out_beat);
		end
	end

	`PSAM_ASSERT_IMP(a_oor_addr_zero, clk, arst_n, addr_valid && out_of_range, source_address == '0, "out-of-range result with nonzero address")
	`PSAM_ASSERT_NXT(a_stall_holds, clk, arst_n, addr_valid && !addr_ready, addr_valid && $stable(source_address) && $stable(out_of_range) && $stable(is_interior), "stalled result changed")
	`PSAM_ASSERT_IMP(a_no_phantom, clk, arst_n, addr_valid, inflight_q != '0, "result beat without an accepted position")
	`PSAM_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1, inflight_q <= CNT_W'(PIPE_DEPTH), "more beats in flight than pipeline stages")

endmodule

bind pad_source_address_mapper_top psam_checker u_psam_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pos_valid(pos.valid),
	.pos_ready(pos.ready),
	.addr_valid(addr.valid),
	.addr_ready(addr.ready),
	.source_address(addr.source_address),
	.out_of_range(addr.out_of_range),
	.is_interior(addr.is_interior)
);

>>> bench/pad_source_address_mapper_top_tb.sv
// Self-checking bench for the padding source address mapper: drives position beats,
// predicts every address beat from a local copy of the registers and checks it.
// Depends on psam_pkg, the psam channel interfaces and pad_source_address_mapper_top.
`timescale 1ns / 1ps

module pad_source_address_mapper_top_tb;
	import psam_pkg::*;

	// Index beyond the last register. A write to it must leave every register alone.
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 4'd15;
	localparam int RANDOM_SETTINGS = 12;
	localparam int BEATS_PER_SETTING = 78;

	// One predicted address beat.
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              oor;
		logic              interior;
	} addr_beat_t;

	// Result of folding one output position back onto one input axis.
	typedef struct packed {
		logic [15:0] idx;
		logic        bad;
		logic        folded;
	} axis_map_t;

	logic clk;
	logic arst_n;

	psam_pos_if  pos_ch ();
	psam_addr_if addr_ch ();
	psam_cfg_if  cfg_ch ();

	pad_source_address_mapper_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos_ch),
		.addr   (addr_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the register file, updated on every accepted write.
	psam_cfg_t geom;

	psam_pos_t  pending_positions[$];
	addr_beat_t expected_addresses[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int beats_checked;
	int oor_seen;
	int interior_seen;
	int settings_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mirrors about the edge without repeating it (reflection) or clamps to the edge
	// (replication). The middle branch is always position minus pad, so a negative pad
	// crops. Any index outside [0, extent) marks the beat out of range.
	function automatic axis_map_t map_axis_index(input logic [POS_W-1:0] pos,
		input logic [EXT_W-1:0] extent, input logic signed [EXT_W-1:0] pad,
		input logic clamp);
		axis_map_t r;
		int j, s, p, m;
		j = pos;
		s = extent;
		p = pad;
		r.folded = 1'b1;
		if (j < p) begin
			m = clamp ? 0 : p - j;
		end else if (j < s + p) begin
			m = j - p;
			r.folded = 1'b0;
		end else begin
			m = clamp ? s - 1 : 2 * s + p - 2 - j;
		end
		r.bad = (m < 0) || (m >= s);
		r.idx = m[15:0];
		return r;
	endfunction

	// Flat input address for one output position. The sums are formed at 64 bits and
	// then cut to the address width, which is the same as wrapping at every step.
	function automatic addr_beat_t map_source_address(input psam_pos_t p, input psam_cfg_t g);
		axis_map_t d, h, w;
		logic [63:0] n, c, cc, dd, hh, ww, a;
		addr_beat_t r;
		d = map_axis_index(p.plane, g.depth, g.pad_front, g.repl);
		h = map_axis_index(p.row, g.height, g.pad_top, g.repl);
		w = map_axis_index(p.col, g.width, g.pad_left, g.repl);
		n = p.batch;
		c = p.chan;
		cc = g.chans;
		dd = g.depth;
		hh = g.height;
		ww = g.width;
		a = 64'd0;
		r.oor = d.bad | h.bad | w.bad;
		r.interior = !(d.folded | h.folded | w.folded);
		if (!r.oor) begin
			if (g.last) begin
				a = (((n * dd + d.idx) * hh + h.idx) * ww + w.idx) * cc + c;
			end else begin
				a = (((n * cc + c) * dd + d.idx) * hh + h.idx) * ww + w.idx;
			end
		end
		r.address = a[ADDR_W-1:0];
		return r;
	endfunction

	// Only the low bits that a register holds are kept; unknown indexes are ignored.
	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_MODE: begin
				geom.repl = value[0];
				geom.last = value[1];
			end
			REG_CHANNELS:  geom.chans = value;
			REG_DEPTH:     geom.depth = value[EXT_W-1:0];
			REG_HEIGHT:    geom.height = value[EXT_W-1:0];
			REG_WIDTH:     geom.width = value[EXT_W-1:0];
			REG_PAD_FRONT: geom.pad_front = value[EXT_W-1:0];
			REG_PAD_TOP:   geom.pad_top = value[EXT_W-1:0];
			REG_PAD_LEFT:  geom.pad_left = value[EXT_W-1:0];
			default: ;
		endcase
	endfunction

	// One configuration beat. The local copy changes at the edge that accepts it, so
	// every position beat queued afterwards is predicted with the new setting.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		apply_reg_write(idx, value);
	endtask

	task automatic write_geometry(input logic [CFG_DATA_W-1:0] mode, chans, depth, height, width,
		input logic [CFG_DATA_W-1:0] pad_front, pad_top, pad_left);
		write_reg(REG_MODE, mode);
		write_reg(REG_CHANNELS, chans);
		write_reg(REG_DEPTH, depth);
		write_reg(REG_HEIGHT, height);
		write_reg(REG_WIDTH, width);
		write_reg(REG_PAD_FRONT, pad_front);
		write_reg(REG_PAD_TOP, pad_top);
		write_reg(REG_PAD_LEFT, pad_left);
		settings_count++;
	endtask

	task automatic queue_position(input logic [BATCH_W-1:0] batch, input logic [POS_W-1:0] chan,
		input logic [POS_W-1:0] plane, row, col);
		psam_pos_t p;
		p.batch = batch;
		p.chan  = chan;
		p.plane = plane;
		p.row   = row;
		p.col   = col;
		pending_positions.push_back(p);
	endtask

	// Checked on the falling edge, where every update of the rising edge has settled.
	// The block is idle once nothing is queued, nothing is on the wire and every
	// predicted address has come back.
	task automatic wait_for_drain();
		@(negedge clk);
		while (pending_positions.size() != 0 || pos_ch.valid || expected_addresses.size() != 0)
			@(negedge clk);
	endtask

	// Mostly small extents so that positions reach every branch; now and then a
	// zero or a full-range value, with random bits above the register width.
	function automatic logic [CFG_DATA_W-1:0] random_extent();
		logic [EXT_W-1:0] e;
		case ($urandom_range(15))
			0:       e = '0;
			1, 2:    e = EXT_W'($urandom);
			default: e = EXT_W'($urandom_range(1, 9));
		endcase
		return {2'($urandom), e};
	endfunction

	// Pads mostly near the extent on either side, so that mirroring past the edge,
	// cropping and pads not smaller than the extent all show up.
	function automatic logic [CFG_DATA_W-1:0] random_pad(input logic [CFG_DATA_W-1:0] extent);
		int e, v;
		e = extent[EXT_W-1:0];
		if ($urandom_range(7) == 0) begin
			v = int'($urandom_range(2047)) - 1024;
		end else begin
			v = int'($urandom_range(2 * e + 4)) - (e + 2);
			if (v > 1023) v = 1023;
			if (v < -1024) v = -1024;
		end
		return {2'($urandom), EXT_W'(v)};
	endfunction

	function automatic logic [POS_W-1:0] random_position(input logic [EXT_W-1:0] extent,
		input logic signed [EXT_W-1:0] pad);
		int e, p, hi;
		e = extent;
		p = pad;
		if ($urandom_range(7) == 0) return POS_W'($urandom);
		hi = e + 2 * (p < 0 ? -p : p) + 4;
		if (hi > 4095) hi = 4095;
		return POS_W'($urandom_range(hi));
	endfunction

	// Position driver. A beat is accepted on an edge with valid and ready high; its
	// prediction is taken right there, with the register copy in force for it. A new
	// beat goes out only when the wire is free, after a random idle draw.
	always @(posedge clk) begin : position_driver
		psam_pos_t beat;
		psam_pos_t nxt;
		if (!arst_n) begin
			pos_ch.valid <= 1'b0;
		end else begin
			if (pos_ch.valid && pos_ch.ready) begin
				beat = {pos_ch.batch_idx, pos_ch.chan_idx, pos_ch.out_plane, pos_ch.out_row,
					pos_ch.out_col};
				expected_addresses.push_back(map_source_address(beat, geom));
			end
			if (!pos_ch.valid || pos_ch.ready) begin
				if (pending_positions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_positions.pop_front();
					pos_ch.valid     <= 1'b1;
					pos_ch.batch_idx <= nxt.batch;
					pos_ch.chan_idx  <= nxt.chan;
					pos_ch.out_plane <= nxt.plane;
					pos_ch.out_row   <= nxt.row;
					pos_ch.out_col   <= nxt.col;
				end else begin
					pos_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Address monitor. Ready is drawn at random each cycle; every accepted beat is
	// compared field by field with the oldest prediction.
	always @(posedge clk) begin : address_monitor
		addr_beat_t want;
		if (!arst_n) begin
			addr_ch.ready <= 1'b0;
		end else begin
			addr_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (addr_ch.valid && addr_ch.ready) begin
				if (expected_addresses.size() == 0) begin
					$error("address beat with nothing expected: source_address %h",
						addr_ch.source_address);
					fail_count++;
				end else begin
					want = expected_addresses.pop_front();
					beats_checked++;
					if (want.oor) oor_seen++;
					if (want.interior) interior_seen++;
					if (addr_ch.source_address !== want.address) begin
						$error("source_address: expected %h, got %h", want.address,
							addr_ch.source_address);
						fail_count++;
					end
					if (addr_ch.out_of_range !== want.oor) begin
						$error("out_of_range: expected %b, got %b", want.oor,
							addr_ch.out_of_range);
						fail_count++;
					end
					if (addr_ch.is_interior !== want.interior) begin
						$error("is_interior: expected %b, got %b", want.interior,
							addr_ch.is_interior);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] mode_w, chan_w, dep_w, hgt_w, wid_w;
		logic [POS_W-1:0] chan_pick;

		// Every input is known from time zero, with reset held low.
		arst_n           = 1'b0;
		pos_ch.valid     = 1'b0;
		pos_ch.batch_idx = '0;
		pos_ch.chan_idx  = '0;
		pos_ch.out_plane = '0;
		pos_ch.out_row   = '0;
		pos_ch.out_col   = '0;
		addr_ch.ready    = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		geom             = '0;
		geom.chans       = CH_W'(1);
		geom.depth       = EXT_W'(1);
		geom.height      = EXT_W'(1);
		geom.width       = EXT_W'(1);
		fail_count       = 0;
		beats_checked    = 0;
		oor_seen         = 0;
		interior_seen    = 0;
		settings_count   = 1;
		send_idle_pct    = 13;
		recv_stall_pct   = 83;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a 1x1x1 input with no padding. The origin is interior and
		// address zero; the far corner mirrors below zero and falls out of range.
		queue_position(0, 0, 0, 0, 0);
		queue_position(255, 4095, 4095, 4095, 4095);
		wait_for_drain();

		// Extents of 1024 with reflection pads one short of them: mirror at the
		// low edge, both middle limits, the first mirrored beat past the high edge, and
		// a position so far out that the mirror lands below zero.
		write_geometry(0, 4096, 1024, 1024, 1024, 1023, 1023, 1023);
		queue_position(255, 4095, 0, 1023, 2046);
		queue_position(255, 4095, 2047, 4095, 1);
		queue_position(0, 0, 1024, 1024, 1024);
		wait_for_drain();

		// Replication, channels last, with a cropping pad on depth: clamps at the high edge
		// on every axis and at the low edge on columns, and one beat that stays interior.
		write_geometry(3, 3, 5, 1, 7, CFG_DATA_W'(-2), 0, 3);
		queue_position(7, 2, 0, 0, 0);
		queue_position(7, 2, 4, 5, 12);
		queue_position(200, 1, 1, 0, 5);
		wait_for_drain();

		// A crop of 1023 on every axis: the middle branch starts at 1023 and everything after it clamps.
		write_geometry(1, 1, 1024, 1024, 1024, CFG_DATA_W'(-1023), CFG_DATA_W'(-1023),
			CFG_DATA_W'(-1023));
		queue_position(0, 0, 0, 0, 0);
		queue_position(0, 0, 1, 1, 1);
		queue_position(0, 0, 4095, 0, 0);
		wait_for_drain();

		// A zero extent leaves no index inside the input; zero channels and the most
		// negative pad ride along.
		write_geometry(2, 0, 0, 2047, 2047, 13'h0400, 0, 0);
		queue_position(9, 17, 0, 100, 100);
		wait_for_drain();

		// Register maxima with spare mode bits set: the address wraps past its width.
		write_geometry(13'h1FFE, 8191, 2047, 2047, 2047, 0, 0, 0);
		queue_position(255, 4095, 2046, 2046, 2046);
		wait_for_drain();

		// A reflection pad equal to its extent is out of range at position zero; a
		// channel index above the channel count goes unchecked. The write to an
		// unused index must change nothing.
		write_geometry(0, 2, 3, 3, 3, 3, 2, 1);
		write_reg(UNUSED_REG_INDEX, 13'h1FFF);
		queue_position(0, 5, 0, 0, 0);
		queue_position(1, 1, 3, 2, 5);
		wait_for_drain();

		// Random settings, each followed by a burst of positions scattered around the
		// padded extent. Every setting starts only once the previous burst has fully
		// drained, so the sender also sits out until nothing is outstanding.
		for (int s = 0; s < RANDOM_SETTINGS; s++) begin
			if (s == RANDOM_SETTINGS / 3) begin
				send_idle_pct  = 83;
				recv_stall_pct = 13;
			end else if (s == 2 * RANDOM_SETTINGS / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			mode_w = CFG_DATA_W'($urandom);
			chan_w = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom)
				: CFG_DATA_W'($urandom_range(1, 16));
			dep_w = random_extent();
			hgt_w = random_extent();
			wid_w = random_extent();
			write_geometry(mode_w, chan_w, dep_w, hgt_w, wid_w, random_pad(dep_w),
				random_pad(hgt_w), random_pad(wid_w));
			for (int i = 0; i < BEATS_PER_SETTING; i++) begin
				chan_pick = (geom.chans != 0 && $urandom_range(7) != 0)
					? POS_W'($urandom_range(geom.chans - 1)) : POS_W'($urandom);
				queue_position(BATCH_W'($urandom), chan_pick,
					random_position(geom.depth, geom.pad_front),
					random_position(geom.height, geom.pad_top),
					random_position(geom.width, geom.pad_left));
			end
			wait_for_drain();
		end

		// Anything the block emits after the last prediction is caught by the monitor.
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		$display("Checked %0d address beats over %0d register settings.", beats_checked,
			settings_count);
		$display("%0d beats were out of range and %0d interior.", oor_seen, interior_seen);
		if (fail_count == 0 && expected_addresses.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run of this stimulus.
	initial begin
		#400000;
		$display("Timed out with %0d address beats outstanding.", expected_addresses.size());
		$display("status: fail");
		$finish;
	end

endmodule
